>>> src/page_segment_lru_read_cache_assert.svh
// Assertion macros for the segment cache control logic.
// Depends on nothing; included by the top level after its declarations.
`ifndef PAGE_SEGMENT_LRU_READ_CACHE_ASSERT_SVH
`define PAGE_SEGMENT_LRU_READ_CACHE_ASSERT_SVH

// check a consequence in the same cycle
`define PSLRC_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("pslrc: same-cycle check failed");

// check a consequence in the next cycle
`define PSLRC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("pslrc: next-cycle check failed");

`endif

>>> src/pslrc_pkg.sv
// Shared types and codes of the segment cache control logic.
// Depends on nothing; used by page_segment_lru_read_cache and the bench.
`timescale 1ns / 1ps
`default_nettype none

package pslrc_pkg;

    typedef enum logic [1:0] {
        OUTCOME_HIT    = 2'd0,
        OUTCOME_MISS   = 2'd1,
        OUTCOME_BYPASS = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [30:0] byte_pos;
        logic [15:0] byte_len;
        logic        direct_to_caller;
    } req_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [2:0]  slot;
        logic [10:0] offset;
        logic [30:0] fill_pos;
        logic [10:0] fill_len;
    } rsp_t;

endpackage

`default_nettype wire

>>> src/pslrc_order_mem.sv
// Recency list memory: slot number at each recency position, registered read.
// Per-entry valid flags make an unwritten position read as its own index.
`timescale 1ns / 1ps
`default_nettype none

module pslrc_order_mem #(
    parameter int NUM_SEGMENTS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            rd_en,
    input  wire logic [$clog2(NUM_SEGMENTS)-1:0] rd_addr,
    output logic      [$clog2(NUM_SEGMENTS)-1:0] rd_data,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(NUM_SEGMENTS)-1:0] wr_addr,
    input  wire logic [$clog2(NUM_SEGMENTS)-1:0] wr_data
);

    localparam int SLOT_W = $clog2(NUM_SEGMENTS);

    logic [SLOT_W-1:0]       mem [NUM_SEGMENTS];
    logic [NUM_SEGMENTS-1:0] valid_reg;
    logic [SLOT_W-1:0]       rd_raw_reg;
    logic [SLOT_W-1:0]       rd_addr_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_addr_reg <= rd_addr;
                rd_vld_reg  <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten position holds the slot of the same number
    assign rd_data = rd_vld_reg ? rd_raw_reg : rd_addr_reg;

endmodule

`default_nettype wire

>>> src/page_segment_lru_read_cache.sv
// Bypass goes to the result without a walk; a hit ends the walk at its recency position;
// a miss either finds a window too short for the request or walks every entry.
// Flow: one transaction at a time, the next one accepted at the earliest in the cycle
// after the previous result loads; the walk reads one recency entry and one tag
// per cycle through the two registered-read memories. A held result adds its stall.
// Reset: all tags invalid, slot i at recency position i, media_size 0; no sweep.
`timescale 1ns / 1ps
`default_nettype none

module page_segment_lru_read_cache #(
    parameter int NUM_SEGMENTS  = 8,
    parameter int PAGE_BYTES    = 512,
    parameter int SEGMENT_BYTES = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [30:0]      cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pslrc_pkg::req_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pslrc_pkg::rsp_t       out_data
);

    localparam int          SLOT_W    = $clog2(NUM_SEGMENTS);
    localparam int          CNT_W     = $clog2(NUM_SEGMENTS + 1);
    localparam logic [30:0] PAGE_MASK = 31'(PAGE_BYTES - 1);
    localparam logic [31:0] SEG_SPAN  = 32'(SEGMENT_BYTES);
    localparam logic [15:0] BYP_LIMIT = 16'(SEGMENT_BYTES / 2);
    localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(NUM_SEGMENTS);
    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(NUM_SEGMENTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t            state_reg,    state_next;
    pslrc_pkg::req_t   req_reg,      req_next;
    logic [CNT_W-1:0]  rd_cnt_reg,   rd_cnt_next;
    logic              s1_vld_reg,   s1_vld_next;
    logic [SLOT_W-1:0] s1_idx_reg,   s1_idx_next;
    logic              s2_vld_reg,   s2_vld_next;
    logic [SLOT_W-1:0] s2_idx_reg,   s2_idx_next;
    logic [SLOT_W-1:0] s2_slot_reg,  s2_slot_next;
    logic              tag_vld_rd_reg, tag_vld_rd_next;
    logic [SLOT_W-1:0] carry_reg,    carry_next;
    logic              fin_byp_reg,  fin_byp_next;
    logic              fin_hit_reg,  fin_hit_next;
    logic [SLOT_W-1:0] fin_slot_reg, fin_slot_next;
    logic [10:0]       fin_off_reg,  fin_off_next;
    logic              out_valid_reg, out_valid_next;
    pslrc_pkg::rsp_t   out_data_reg, out_data_next;
    logic [NUM_SEGMENTS-1:0] tag_valid_reg, tag_valid_next;
    logic [30:0]       media_size_reg, media_size_next;

    logic [30:0]       tag_mem [NUM_SEGMENTS];
    logic [30:0]       tag_rd_reg;

    logic              issue;
    logic              cmp;
    logic              out_free;
    logic              tag_wr_en;
    logic              ord_wr_en;
    logic [SLOT_W-1:0] ord_wr_addr;
    logic [SLOT_W-1:0] ord_wr_data;
    logic [SLOT_W-1:0] ord_rd_data;
    logic [31:0]       pos_ext;
    logic [31:0]       tag_ext;
    logic [31:0]       seg_end;
    logic [31:0]       req_end;
    logic [31:0]       hit_off;
    logic              in_win;
    logic              fits;
    logic [30:0]       page_pos;
    logic [30:0]       page_off;
    logic [30:0]       remain;
    logic [31:0]       fill_full;
    logic [SLOT_W+2:0] slot_wide;
    pslrc_pkg::rsp_t   result;

    pslrc_order_mem #(
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_order (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[SLOT_W-1:0]),
        .rd_data (ord_rd_data),
        .wr_en   (ord_wr_en),
        .wr_addr (ord_wr_addr),
        .wr_data (ord_wr_data)
    );

    always_ff @(posedge clk)
    begin
        if (tag_wr_en)
        begin
            tag_mem[fin_slot_reg] <= page_pos;
        end
        if (s1_vld_reg)
        begin
            tag_rd_reg <= tag_mem[ord_rd_data];
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign issue    = (state_reg == ST_SEARCH) && (rd_cnt_reg != CNT_END);
    assign cmp      = (state_reg == ST_SEARCH) && s2_vld_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign pos_ext = {1'b0, req_reg.byte_pos};
    assign tag_ext = {1'b0, tag_rd_reg};
    assign seg_end = tag_ext + SEG_SPAN;
    assign req_end = pos_ext + {16'b0, req_reg.byte_len};
    assign hit_off = pos_ext - tag_ext;
    assign in_win  = tag_vld_rd_reg && (tag_ext <= pos_ext) && (pos_ext <= seg_end);
    assign fits    = (req_end <= seg_end);

    assign page_pos  = req_reg.byte_pos & ~PAGE_MASK;
    assign page_off  = req_reg.byte_pos & PAGE_MASK;
    assign remain    = (media_size_reg > page_pos) ? (media_size_reg - page_pos) : '0;
    assign fill_full = ({1'b0, remain} < SEG_SPAN) ? {1'b0, remain} : SEG_SPAN;
    assign slot_wide = {3'b000, fin_slot_reg};

    assign tag_wr_en = (state_reg == ST_FINISH) && !fin_byp_reg && !fin_hit_reg;

    // shift each passed entry down one position; finish by writing the front
    always_comb
    begin
        ord_wr_en   = 1'b0;
        ord_wr_addr = s2_idx_reg;
        ord_wr_data = carry_reg;
        if (cmp && (s2_idx_reg != '0))
        begin
            ord_wr_en = 1'b1;
        end
        else if ((state_reg == ST_FINISH) && !fin_byp_reg)
        begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = '0;
            ord_wr_data = fin_slot_reg;
        end
    end

    always_comb
    begin
        result = '0;
        if (fin_byp_reg)
        begin
            result.outcome = pslrc_pkg::OUTCOME_BYPASS;
        end
        else if (fin_hit_reg)
        begin
            result.outcome = pslrc_pkg::OUTCOME_HIT;
            result.slot    = slot_wide[2:0];
            result.offset  = fin_off_reg;
        end
        else
        begin
            result.outcome  = pslrc_pkg::OUTCOME_MISS;
            result.slot     = slot_wide[2:0];
            result.offset   = fin_off_reg;
            result.fill_pos = page_pos;
            result.fill_len = fill_full[10:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rd_cnt_next     = rd_cnt_reg;
        s1_vld_next     = 1'b0;
        s1_idx_next     = rd_cnt_reg[SLOT_W-1:0];
        s2_vld_next     = 1'b0;
        s2_idx_next     = s1_idx_reg;
        s2_slot_next    = ord_rd_data;
        tag_vld_rd_next = tag_valid_reg[ord_rd_data];
        carry_next      = carry_reg;
        fin_byp_next    = fin_byp_reg;
        fin_hit_next    = fin_hit_reg;
        fin_slot_next   = fin_slot_reg;
        fin_off_next    = fin_off_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        tag_valid_next  = tag_valid_reg;
        media_size_next = cfg_valid ? cfg_data : media_size_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = in_data;
                    rd_cnt_next  = '0;
                    fin_byp_next = in_data.direct_to_caller || (in_data.byte_len > BYP_LIMIT);
                    state_next   = fin_byp_next ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                s1_vld_next = issue;
                s2_vld_next = s1_vld_reg;
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (cmp)
                begin
                    if (in_win)
                    begin
                        fin_hit_next  = fits;
                        fin_slot_next = s2_slot_reg;
                        fin_off_next  = fits ? hit_off[10:0] : page_off[10:0];
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        carry_next = s2_slot_reg;
                        if (s2_idx_reg == IDX_LAST)
                        begin
                            fin_hit_next  = 1'b0;
                            fin_slot_next = s2_slot_reg;
                            fin_off_next  = page_off[10:0];
                            state_next    = ST_FINISH;
                        end
                    end
                end
                if (state_next != ST_SEARCH)
                begin
                    s1_vld_next = 1'b0;
                    s2_vld_next = 1'b0;
                end
            end
            ST_FINISH:
            begin
                if (tag_wr_en)
                begin
                    tag_valid_next[fin_slot_reg] = 1'b1;
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= '0;
            rd_cnt_reg     <= '0;
            s1_vld_reg     <= 1'b0;
            s1_idx_reg     <= '0;
            s2_vld_reg     <= 1'b0;
            s2_idx_reg     <= '0;
            s2_slot_reg    <= '0;
            tag_vld_rd_reg <= 1'b0;
            carry_reg      <= '0;
            fin_byp_reg    <= 1'b0;
            fin_hit_reg    <= 1'b0;
            fin_slot_reg   <= '0;
            fin_off_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            tag_valid_reg  <= '0;
            media_size_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            rd_cnt_reg     <= rd_cnt_next;
            s1_vld_reg     <= s1_vld_next;
            s1_idx_reg     <= s1_idx_next;
            s2_vld_reg     <= s2_vld_next;
            s2_idx_reg     <= s2_idx_next;
            s2_slot_reg    <= s2_slot_next;
            tag_vld_rd_reg <= tag_vld_rd_next;
            carry_reg      <= carry_next;
            fin_byp_reg    <= fin_byp_next;
            fin_hit_reg    <= fin_hit_next;
            fin_slot_reg   <= fin_slot_next;
            fin_off_reg    <= fin_off_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            tag_valid_reg  <= tag_valid_next;
            media_size_reg <= media_size_next;
        end
    end

`include "page_segment_lru_read_cache_assert.svh"

    `PSLRC_ASSERT_NEXT(a_accept_blocks, clk, rst_n, in_valid && in_ready, !in_ready)
    `PSLRC_ASSERT_NOW(a_walk_only_in_search, clk, rst_n, s2_vld_reg, state_reg == ST_SEARCH)
    `PSLRC_ASSERT_NEXT(a_finish_delivers, clk, rst_n, (state_reg == ST_FINISH) && out_free, out_valid_reg && (state_reg == ST_IDLE))

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for the LRU segment cache control block: predicts every
// hit, miss and bypass with its own tag and recency model and checks each result.
// Depends on pslrc_pkg and page_segment_lru_read_cache from src.
`timescale 1ns / 1ps

module tb_top;

    localparam int NSEG = 8;
    localparam int PAGE_B = 512;
    localparam int SEG_B = 1024;
    localparam int HALF_SEG = SEG_B / 2;
    localparam int DRAIN_CYCLES = NSEG + 12;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_IDLE = 18;
    localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [30:0]       cfg_data;
    logic              in_valid;
    logic              in_ready;
    pslrc_pkg::req_t   in_data;
    logic              out_valid;
    logic              out_ready;
    pslrc_pkg::rsp_t   out_data;

    logic [31:0] seg_tag [NSEG];
    logic [2:0]  lru_order [NSEG];
    logic [30:0] media_bytes;

    pslrc_pkg::rsp_t lookup_q [$];
    int          mismatch_count;
    int          cycle_count;
    int          hold_cycles;
    bit          tx_idle;
    bit          rx_idle;
    logic [30:0] region_base [16];
    int          region_count;

    page_segment_lru_read_cache #(
        .NUM_SEGMENTS  (NSEG),
        .PAGE_BYTES    (PAGE_B),
        .SEGMENT_BYTES (SEG_B)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void promote_entry(int p);
        logic [2:0] s;
        s = lru_order[p];
        for (int i = p; i > 0; i--)
            lru_order[i] = lru_order[i - 1];
        lru_order[0] = s;
    endfunction

    function automatic void demote_entry(int p);
        logic [2:0] s;
        s = lru_order[p];
        for (int i = p; i < NSEG - 1; i++)
            lru_order[i] = lru_order[i + 1];
        lru_order[NSEG - 1] = s;
    endfunction

    function automatic pslrc_pkg::rsp_t predict_lookup(pslrc_pkg::req_t r);
        pslrc_pkg::rsp_t res;
        logic [32:0] pos;
        logic [32:0] seg_end;
        logic [31:0] tg;
        logic [30:0] page;
        logic [31:0] remain;
        logic [2:0]  s;
        bit          done;
        int          p;
        res = '0;
        if (r.byte_len > HALF_SEG || r.direct_to_caller)
        begin
            res.outcome = pslrc_pkg::OUTCOME_BYPASS;
            return res;
        end
        pos = {2'b0, r.byte_pos};
        done = 0;
        p = 0;
        while (!done && p < NSEG)
        begin
            s = lru_order[p];
            tg = seg_tag[s];
            seg_end = {1'b0, tg} + 33'(SEG_B);
            if (!tg[31] && {1'b0, tg} <= pos && seg_end >= pos)
            begin
                done = 1;
                if (pos + {17'b0, r.byte_len} > seg_end)
                    demote_entry(p);
                else
                begin
                    promote_entry(p);
                    res.outcome = pslrc_pkg::OUTCOME_HIT;
                    res.slot = s;
                    res.offset = 11'(pos - {1'b0, tg});
                    return res;
                end
            end
            p++;
        end
        page = r.byte_pos & ~31'(PAGE_B - 1);
        s = lru_order[NSEG - 1];
        seg_tag[s] = {1'b0, page};
        promote_entry(NSEG - 1);
        remain = (media_bytes > page) ? 32'(media_bytes - page) : 32'd0;
        res.outcome = pslrc_pkg::OUTCOME_MISS;
        res.slot = s;
        res.offset = 11'(r.byte_pos & 31'(PAGE_B - 1));
        res.fill_pos = page;
        res.fill_len = (remain < SEG_B) ? 11'(remain) : 11'(SEG_B);
        return res;
    endfunction

    function automatic pslrc_pkg::req_t make_req(logic [30:0] pos, logic [15:0] len,
                                                 logic direct);
        pslrc_pkg::req_t r;
        r.byte_pos = pos;
        r.byte_len = len;
        r.direct_to_caller = direct;
        return r;
    endfunction

    task automatic send_req(input pslrc_pkg::req_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lookup_q.push_back(predict_lookup(r));
    endtask

    task automatic wait_results;
        in_valid <= 1'b0;
        while (lookup_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_media_size(input logic [30:0] v);
        wait_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        media_bytes = v;
        cfg_valid <= 1'b0;
    endtask

    // receiver: per-result stall, plus an optional long hold-off
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        pslrc_pkg::rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lookup_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: outcome %0d slot %0d offset %0d pos %h len %0d",
                             out_data.outcome, out_data.slot, out_data.offset,
                             out_data.fill_pos, out_data.fill_len);
                mismatch_count++;
            end
            else
            begin
                want = lookup_q.pop_front();
                if (out_data.outcome !== want.outcome || out_data.slot !== want.slot ||
                    out_data.offset !== want.offset || out_data.fill_pos !== want.fill_pos ||
                    out_data.fill_len !== want.fill_len)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("mismatch: exp outcome %0d slot %0d offset %0d pos %h len %0d",
                                 want.outcome, want.slot, want.offset,
                                 want.fill_pos, want.fill_len);
                        $display("          got outcome %0d slot %0d offset %0d pos %h len %0d",
                                 out_data.outcome, out_data.slot, out_data.offset,
                                 out_data.fill_pos, out_data.fill_len);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_bypass;
        send_req(make_req(POS_MAX, 16'd1, 1'b1));
        send_req(make_req(31'd0, 16'(HALF_SEG + 1), 1'b0));
        send_req(make_req(31'h0000_1234, 16'hFFFF, 1'b0));
    endtask

    task automatic test_hit_window;
        send_req(make_req(31'h0000_1005, 16'd16, 1'b0));
        send_req(make_req(31'h0000_1005, 16'd16, 1'b0));
        send_req(make_req(31'h0000_1400, 16'd0, 1'b0));
        send_req(make_req(31'h0000_1200, 16'(HALF_SEG), 1'b0));
        send_req(make_req(31'h0000_13F0, 16'd32, 1'b0));
    endtask

    task automatic test_top_of_media;
        write_media_size(POS_MAX);
        send_req(make_req(POS_MAX, 16'd1, 1'b0));
        send_req(make_req(POS_MAX, 16'(HALF_SEG), 1'b0));
    endtask

    task automatic test_eviction_and_clip;
        write_media_size(31'h0002_0A00);
        for (int k = 0; k < 10; k++)
            send_req(make_req(31'h0002_0000 + 31'(k * 'h800) + 31'(k), 16'd1, 1'b0));
        send_req(make_req(31'h0002_0000, 16'd4, 1'b0));
        send_req(make_req(31'h0002_4805, 16'd4, 1'b0));
    endtask

    task automatic test_backpressure;
        wait_results();
        tx_idle = 0;
        rx_idle = 0;
        hold_cycles = 400;
        for (int k = 0; k < 12; k++)
            send_req(make_req(31'h0003_0000 + 31'($urandom_range(0, 3000)),
                              16'($urandom_range(1, 600)), 1'($urandom_range(0, 1))));
    endtask

    task automatic pick_regions;
        logic [30:0] b;
        region_count = $urandom_range(4, 14);
        for (int k = 0; k < region_count; k++)
        begin
            if (k > 0 && $urandom_range(0, 2) == 0)
                b = region_base[k - 1] + 31'(PAGE_B);
            else
                b = {22'($urandom), 9'b0};
            if (b > 31'h7FFF_F000)
                b = b - 31'h0000_2000;
            region_base[k] = b;
        end
    endtask

    function automatic pslrc_pkg::req_t random_req();
        int          kind;
        logic [30:0] pos;
        logic [15:0] len;
        kind = $urandom_range(0, 99);
        pos = region_base[$urandom_range(0, region_count - 1)] + 31'($urandom_range(0, 1100));
        if ($urandom_range(0, 3) == 0)
            len = 16'($urandom_range(1, HALF_SEG));
        else if ($urandom_range(0, 49) == 0)
            len = 16'd0;
        else
            len = 16'($urandom_range(1, 64));
        if (kind < 72)
            return make_req(pos, len, 1'b0);
        else if (kind < 82)
            return make_req(pos, 16'($urandom_range(HALF_SEG + 1, 65535)),
                            1'($urandom_range(0, 1)));
        else if (kind < 90)
            return make_req(pos, len, 1'b1);
        else
            return make_req(31'($urandom), 16'($urandom_range(1, HALF_SEG)), 1'b0);
    endfunction

    task automatic test_random;
        logic [30:0] msize;
        for (int ph = 0; ph < 6; ph++)
        begin
            pick_regions();
            case (ph % 4)
                0: msize = region_base[0] + 31'($urandom_range(0, 2048));
                1: msize = POS_MAX;
                2: msize = '0;
                default: msize = 31'($urandom);
            endcase
            write_media_size(msize);
            for (int k = 0; k < 250; k++)
            begin
                if (k % 50 == 0)
                begin
                    tx_idle = $urandom_range(0, 3) != 0;
                    rx_idle = $urandom_range(0, 3) != 0;
                end
                send_req(random_req());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        tx_idle = 1;
        rx_idle = 1;
        region_count = 1;
        media_bytes = '0;
        for (int i = 0; i < NSEG; i++)
        begin
            seg_tag[i] = 32'hFFFF_FFFF;
            lru_order[i] = 3'(i);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bypass();
        test_hit_window();
        test_top_of_media();
        test_eviction_and_clip();
        test_backpressure();
        test_random();

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && lookup_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
